FILE: hdl/bmhq_pkg.sv
// shared types and codes for the binary min-heap queue
package bmhq_pkg;

	// default number of heap slots (slot 0 unused)
	localparam int HEAP_SLOTS_DEF = 64;

	// command codes
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// one heap entry as held in memory
	typedef struct packed {
		logic signed [7:0] weight;
		logic        [7:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/binary_min_heap_queue.sv
// binary min-heap priority queue of (weight, payload) entries in one ram
//
//  channel   handshake          fields
//  --------  -----------------  --------------------------------------------------
//  command   start, busy        command, key_weight, payload
//  result    done (one cycle)   status, removed_weight, removed_payload,
//                               top_valid, top_weight, top_payload, entry_count
//
// a command transfers with start high and busy low; its result shows for one cycle with done
// high and the receiver cannot stall it; a new command may transfer while done is high
// refusals, an insert into an empty heap and an extract of the last entry finish from idle
// other inserts climb through ST_UP (and ST_PLACE at the root); other extracts fetch the
// last entry in ST_DNX and sink through ST_DNL and ST_DNR (ST_PLACE at a leaf); the count
// resets to zero and the ram needs no clearing
module binary_min_heap_queue #(
	parameter int HEAP_SLOTS = bmhq_pkg::HEAP_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic signed [7:0] key_weight,
	input  logic signed [7:0] payload,
	output logic              done,
	output logic        [1:0] status,
	output logic signed [7:0] removed_weight,
	output logic signed [7:0] removed_payload,
	output logic              top_valid,
	output logic signed [7:0] top_weight,
	output logic signed [7:0] top_payload,
	output logic        [5:0] entry_count
);

	localparam int AW = $clog2(HEAP_SLOTS);
	localparam logic [AW-1:0] CAPACITY = AW'(HEAP_SLOTS - 1);
	localparam logic [AW-1:0] ROOT     = AW'(1);

	// controller states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UP    = 3'd1;
	localparam logic [2:0] ST_DNX   = 3'd2;
	localparam logic [2:0] ST_DNL   = 3'd3;
	localparam logic [2:0] ST_DNR   = 3'd4;
	localparam logic [2:0] ST_PLACE = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [AW-1:0]    fill_q, fill_d;
	logic [AW-1:0]    pos_q, pos_d;
	logic             done_q, done_d;
	logic [1:0]       status_q, status_d;
	bmhq_pkg::entry_t x_q, x_d;
	bmhq_pkg::entry_t left_q, left_d;
	bmhq_pkg::entry_t removed_q, removed_d;
	bmhq_pkg::entry_t top_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	bmhq_pkg::entry_t      ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [bmhq_pkg::ENTRY_W-1:0] ram_rdata_raw;
	bmhq_pkg::entry_t      ram_rdata;

	// heap storage
	bmhq_ram #(
		.WIDTH(bmhq_pkg::ENTRY_W),
		.DEPTH(HEAP_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = bmhq_pkg::entry_t'(ram_rdata_raw);

	// child addresses of the hole, one bit wider to hold overflow
	logic [AW:0] lchild;
	logic [AW:0] rchild;
	assign lchild = {pos_q, 1'b0};
	assign rchild = lchild + (AW+1)'(1);

	// pick the smaller child, right one on a tie, left one when there is no right child
	bmhq_pkg::entry_t dn_child;
	logic [AW:0]      dn_caddr;
	logic [AW:0]      dn_next_l;
	always_comb begin
		if (state_q == ST_DNR && ram_rdata.weight <= left_q.weight) begin
			dn_child = ram_rdata;
			dn_caddr = rchild;
		end else if (state_q == ST_DNR) begin
			dn_child = left_q;
			dn_caddr = lchild;
		end else begin
			dn_child = ram_rdata;
			dn_caddr = lchild;
		end
		dn_next_l = {dn_caddr[AW-1:0], 1'b0};
	end

	// climb step: parent slot of the hole
	logic [AW-1:0] up_parent;
	assign up_parent = pos_q >> 1;

	// controller
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		pos_d     = pos_q;
		done_d    = 1'b0;
		status_d  = status_q;
		x_d       = x_q;
		left_d    = left_q;
		removed_d = removed_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = x_q;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					status_d  = bmhq_pkg::STAT_OK;
					removed_d = '0;
					if (command == bmhq_pkg::CMD_INSERT) begin
						x_d.weight  = key_weight;
						x_d.payload = payload;
						if (fill_q == CAPACITY) begin
							status_d = bmhq_pkg::STAT_FULL;
							done_d   = 1'b1;
						end else if (fill_q == '0) begin
							ram_we    = 1'b1;
							ram_waddr = ROOT;
							ram_wdata = x_d;
							fill_d    = ROOT;
							done_d    = 1'b1;
						end else begin
							pos_d     = fill_q + ROOT;
							fill_d    = fill_q + ROOT;
							ram_raddr = pos_d >> 1;
							state_d   = ST_UP;
						end
					end else begin
						if (fill_q == '0) begin
							status_d = bmhq_pkg::STAT_EMPTY;
							done_d   = 1'b1;
						end else begin
							removed_d = top_q;
							fill_d    = fill_q - ROOT;
							if (fill_q == ROOT) begin
								done_d = 1'b1;
							end else begin
								ram_raddr = fill_q;
								pos_d     = ROOT;
								state_d   = ST_DNX;
							end
						end
					end
				end
			end
			ST_UP: begin
				if (ram_rdata.weight > x_q.weight) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = ram_rdata;
					pos_d     = up_parent;
					if (up_parent == ROOT) begin
						state_d = ST_PLACE;
					end else begin
						ram_raddr = up_parent >> 1;
					end
				end else begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = x_q;
					done_d    = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_DNX: begin
				x_d = ram_rdata;
				if (lchild > {1'b0, fill_q}) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = ram_rdata;
					done_d    = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					ram_raddr = lchild[AW-1:0];
					state_d   = ST_DNL;
				end
			end
			ST_DNL, ST_DNR: begin
				if (state_q == ST_DNL && rchild <= {1'b0, fill_q}) begin
					// right child exists, fetch it before deciding
					left_d    = ram_rdata;
					ram_raddr = rchild[AW-1:0];
					state_d   = ST_DNR;
				end else if (x_q.weight > dn_child.weight) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = dn_child;
					pos_d     = dn_caddr[AW-1:0];
					if (dn_next_l > {1'b0, fill_q}) begin
						state_d = ST_PLACE;
					end else begin
						ram_raddr = dn_next_l[AW-1:0];
						state_d   = ST_DNL;
					end
				end else begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = x_q;
					done_d    = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = x_q;
				done_d    = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
		end
	end

	// payload registers; root copy follows every write to the root slot
	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		status_q  <= status_d;
		x_q       <= x_d;
		left_q    <= left_d;
		removed_q <= removed_d;
		if (ram_we && ram_waddr == ROOT) begin
			top_q <= ram_wdata;
		end
	end

	// result ports
	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign removed_weight  = removed_q.weight;
	assign removed_payload = removed_q.payload;
	assign top_valid       = (fill_q != '0);
	assign top_weight      = top_valid ? top_q.weight : 8'sd0;
	assign top_payload     = top_valid ? top_q.payload : 8'sd0;
	assign entry_count     = 6'(fill_q);

endmodule

FILE: hdl/bmhq_ram.sv
// generic single-write, single-read ram with registered read data
module bmhq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
